// File: rtl/sliding_window_receiver_macros.svh
// Assertion macros for the sliding window receiver.
`ifndef SLIDING_WINDOW_RECEIVER_MACROS_SVH
`define SLIDING_WINDOW_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
`define SWR_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("sliding window receiver: check failed");
`define SWR_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("sliding window receiver: check failed");
`else
`define SWR_IMPLY(lbl, ante, cons)
`define SWR_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/swr_pkg.sv
// Shared types and constants of the sliding window receiver.
`timescale 1ns / 1ps
package swr_pkg;
	localparam logic [10:0] MAX_PAYLOAD = 11'd1500;

	localparam logic [1:0] PT_START = 2'd0;
	localparam logic [1:0] PT_END   = 2'd1;

	localparam logic [1:0] K_STORE   = 2'd0;
	localparam logic [1:0] K_DELIVER = 2'd1;
	localparam logic [1:0] K_ACK     = 2'd2;
	localparam logic [1:0] K_STATUS  = 2'd3;

	localparam logic [1:0] STAT_CONN = 2'd0;
	localparam logic [1:0] STAT_DONE = 2'd1;
	localparam logic [1:0] STAT_FAIL = 2'd2;

	localparam logic [1:0] REG_WINDOW  = 2'd0;
	localparam logic [1:0] REG_MODE    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	typedef struct packed {
		logic        tick;
		logic [1:0]  ptype;
		logic [31:0] seq;
		logic [10:0] len;
		logic        good;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  win_pkts;
		logic        ack_mode;
		logic [15:0] timeout_ticks;
	} cfg_t;
endpackage

// File: rtl/swr_front.sv
// Input side: takes words, decodes them and queues commands for the sequencer.
`timescale 1ns / 1ps
module swr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,  // seq[31:0], pkt_length[42:32], checksum_ok[43]
	input  logic [2:0]         s_tuser,  // action[0], pkt_type[2:1]
	output logic               cmd_valid,
	output swr_pkg::cmd_t      cmd,
	input  logic               cmd_pop
);
	import swr_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push;

	always_comb begin
		dec.tick  = s_tuser[0];
		dec.ptype = s_tuser[2:1];
		dec.seq   = s_tdata[31:0];
		dec.len   = (s_tdata[42:32] > MAX_PAYLOAD) ? MAX_PAYLOAD : s_tdata[42:32];
		dec.good  = s_tdata[43];
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

// File: rtl/swr_back.sv
// Sequencer: runs the connection, the window store and in-order release.
`timescale 1ns / 1ps
module swr_back #(
	parameter int WINDOW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  swr_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  swr_pkg::cfg_t      cfg,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [55:0]        m_tdata,  // slot[4:0], length[15:5], ack_seq[47:16], status[49:48]
	output logic [1:0]         m_tuser,  // kind[1:0]
	output logic               m_tlast
);
	import swr_pkg::*;

	localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ACK1  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_STORE = 3'd3;
	localparam logic [2:0] ST_REL   = 3'd4;
	localparam logic [2:0] ST_ACK2  = 3'd5;
	localparam logic [2:0] ST_STAT  = 3'd6;

	localparam logic [1:0] PH_LISTEN = 2'd0;
	localparam logic [1:0] PH_CONN   = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;
	localparam logic [1:0] PH_FAIL   = 2'd3;

	logic [2:0]  state_q;
	logic [1:0]  phase_q;
	logic [31:0] ne_q;
	logic [WINDOW-1:0] filled_q;
	logic [10:0] len_mem [WINDOW];
	logic [15:0] idle_q;
	logic [5:0]  w_q;
	logic        mode_q;
	logic [31:0] ack_q;
	logic        ack_last_q;
	logic [2:0]  ack_next_q;
	logic [1:0]  stat_q;
	logic [5:0]  off_q;
	logic [10:0] len_q;
	logic [5:0]  rem_q;
	logic [31:0] nsh_q;
	logic [2:0]  cnt_q;
	logic [5:0]  rptr_q;

	logic        ov_q;
	logic [1:0]  okind_q;
	logic [4:0]  oslot_q;
	logic [10:0] olen_q;
	logic [31:0] oack_q;
	logic [1:0]  ostat_q;
	logic        olast_q;

	logic [5:0]  wu;
	logic [31:0] off_full;
	logic        in_win;
	logic [15:0] idle_inc;
	logic [5:0]  rem_nx;
	logic [6:0]  ssum;
	logic [5:0]  sslot;
	logic        head_filled;
	logic [5:0]  nr;
	logic        fnext;
	logic        can_emit;

	always_comb begin
		if (cfg.win_pkts == 6'd0) begin
			wu = 6'd1;
		end else if (cfg.win_pkts > 6'(WINDOW)) begin
			wu = 6'(WINDOW);
		end else begin
			wu = cfg.win_pkts;
		end
		off_full = cmd.seq - ne_q;
		in_win   = off_full < {26'd0, wu};
		idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	end

	// Four bits of the dividend per cycle, most significant first.
	always_comb begin
		logic [5:0] r;
		r = rem_q;
		for (int i = 0; i < 4; i++) begin
			r = {r[4:0], nsh_q[31-i]};
			if (r >= w_q) begin
				r = r - w_q;
			end
		end
		rem_nx = r;
	end

	always_comb begin
		ssum        = {1'b0, rem_q} + {1'b0, off_q};
		sslot       = (ssum >= {1'b0, w_q}) ? 6'(ssum - {1'b0, w_q}) : ssum[5:0];
		head_filled = filled_q[rem_q[SW-1:0]] || (sslot == rem_q);
		nr          = (rptr_q + 6'd1 == w_q) ? 6'd0 : rptr_q + 6'd1;
		fnext       = (nr != rptr_q) && filled_q[nr[SW-1:0]];
	end

	assign can_emit = !ov_q || m_tready;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;

	always_ff @(posedge clk) begin
		if (state_q == ST_STORE && can_emit) begin
			len_mem[sslot[SW-1:0]] <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_LISTEN;
			ne_q       <= '0;
			filled_q   <= '0;
			idle_q     <= '0;
			w_q        <= 6'd1;
			mode_q     <= 1'b0;
			ack_q      <= '0;
			ack_last_q <= 1'b0;
			ack_next_q <= ST_IDLE;
			stat_q     <= STAT_CONN;
			off_q      <= '0;
			len_q      <= '0;
			rem_q      <= '0;
			nsh_q      <= '0;
			cnt_q      <= '0;
			rptr_q     <= '0;
			ov_q       <= 1'b0;
			okind_q    <= K_STORE;
			oslot_q    <= '0;
			olen_q     <= '0;
			oack_q     <= '0;
			ostat_q    <= '0;
			olast_q    <= 1'b0;
		end else begin
			if (m_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && (phase_q == PH_LISTEN || phase_q == PH_CONN)) begin
						if (cmd.tick) begin
							idle_q <= idle_inc;
							if (idle_inc >= cfg.timeout_ticks) begin
								phase_q <= PH_FAIL;
								stat_q  <= STAT_FAIL;
								state_q <= ST_STAT;
							end
						end else if (phase_q == PH_LISTEN) begin
							if (!cmd.good || cmd.ptype == PT_END) begin
								phase_q <= PH_FAIL;
								stat_q  <= STAT_FAIL;
								state_q <= ST_STAT;
							end else if (cmd.ptype == PT_START) begin
								ack_q      <= cmd.seq;
								ack_last_q <= 1'b0;
								ack_next_q <= ST_STAT;
								stat_q     <= STAT_CONN;
								phase_q    <= PH_CONN;
								ne_q       <= '0;
								idle_q     <= '0;
								filled_q   <= '0;
								state_q    <= ST_ACK1;
							end
						end else begin
							idle_q <= '0;
							if (cmd.good) begin
								if (cmd.ptype == PT_END) begin
									ack_q      <= cfg.ack_mode ? cmd.seq : ne_q;
									ack_last_q <= 1'b0;
									ack_next_q <= ST_STAT;
									stat_q     <= STAT_DONE;
									phase_q    <= PH_DONE;
									state_q    <= ST_ACK1;
								end else begin
									w_q    <= wu;
									mode_q <= cfg.ack_mode;
									off_q  <= off_full[5:0];
									len_q  <= cmd.len;
									nsh_q  <= ne_q;
									rem_q  <= '0;
									cnt_q  <= '0;
									if (cfg.ack_mode) begin
										ack_q      <= cmd.seq;
										ack_last_q <= !in_win;
										ack_next_q <= in_win ? ST_MOD : ST_IDLE;
										state_q    <= ST_ACK1;
									end else begin
										state_q <= in_win ? ST_MOD : ST_ACK2;
									end
								end
							end
						end
					end
				end
				ST_ACK1: begin
					if (can_emit) begin
						ov_q    <= 1'b1;
						okind_q <= K_ACK;
						oslot_q <= '0;
						olen_q  <= '0;
						oack_q  <= ack_q;
						ostat_q <= '0;
						olast_q <= ack_last_q;
						state_q <= ack_next_q;
					end
				end
				ST_MOD: begin
					rem_q <= rem_nx;
					nsh_q <= {nsh_q[27:0], 4'd0};
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (can_emit) begin
						filled_q[sslot[SW-1:0]] <= 1'b1;
						rptr_q  <= rem_q;
						ov_q    <= 1'b1;
						okind_q <= K_STORE;
						oslot_q <= sslot[4:0];
						olen_q  <= len_q;
						oack_q  <= '0;
						ostat_q <= '0;
						olast_q <= mode_q && !head_filled;
						if (head_filled) begin
							state_q <= ST_REL;
						end else begin
							state_q <= mode_q ? ST_IDLE : ST_ACK2;
						end
					end
				end
				ST_REL: begin
					if (can_emit) begin
						filled_q[rptr_q[SW-1:0]] <= 1'b0;
						ne_q    <= ne_q + 32'd1;
						rptr_q  <= nr;
						ov_q    <= 1'b1;
						okind_q <= K_DELIVER;
						oslot_q <= rptr_q[4:0];
						olen_q  <= len_mem[rptr_q[SW-1:0]];
						oack_q  <= '0;
						ostat_q <= '0;
						olast_q <= mode_q && !fnext;
						if (!fnext) begin
							state_q <= mode_q ? ST_IDLE : ST_ACK2;
						end
					end
				end
				ST_ACK2: begin
					if (can_emit) begin
						ov_q    <= 1'b1;
						okind_q <= K_ACK;
						oslot_q <= '0;
						olen_q  <= '0;
						oack_q  <= ne_q;
						ostat_q <= '0;
						olast_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_STAT: begin
					if (can_emit) begin
						ov_q    <= 1'b1;
						okind_q <= K_STATUS;
						oslot_q <= '0;
						olen_q  <= '0;
						oack_q  <= '0;
						ostat_q <= stat_q;
						olast_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {6'd0, ostat_q, oack_q, olen_q, oslot_q};
endmodule

// File: rtl/sliding_window_receiver.sv
// Sliding window receiver: an input queue, the release sequencer and configuration registers.
//
// Receiver control path of a reliable datagram transfer. Words on the slave side are packet
// arrivals or time ticks; words on the master side tell the payload store what to keep,
// what to hand on in order, which acks to send and how the transfer stands. A two-word
// queue sits between input and sequencer, and one output register holds each result. For a
// data packet in the window, the slot number is found by a remainder unit that works four
// bits of the expected sequence number per cycle, most significant first, and the release
// walks one slot per cycle while m_tready does not hold the output. The configuration must
// be written only while no word is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
module sliding_window_receiver #(
	parameter int WINDOW = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // seq[31:0], pkt_length[42:32], checksum_ok[43]
	input  logic [2:0]  s_tuser,   // action[0], pkt_type[2:1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // slot[4:0], length[15:5], ack_seq[47:16], status[49:48]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import swr_pkg::*;
	`include "sliding_window_receiver_macros.svh"

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_pkts      <= 6'd32;
			cfg_q.ack_mode      <= 1'b0;
			cfg_q.timeout_ticks <= 16'd10000;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WINDOW:  cfg_q.win_pkts      <= cfg_wdata[5:0];
				REG_MODE:    cfg_q.ack_mode      <= cfg_wdata[0];
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	swr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	swr_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	`SWR_IMPLY(a_status_last, m_tvalid && m_tuser == K_STATUS, m_tlast)
	`SWR_IMPLY(a_len_bound, m_tvalid && (m_tuser == K_STORE || m_tuser == K_DELIVER), m_tdata[15:5] <= MAX_PAYLOAD)
	`SWR_IMPLY(a_slot_bound, m_tvalid && (m_tuser == K_STORE || m_tuser == K_DELIVER), 32'(m_tdata[4:0]) < 32'(WINDOW))
	`SWR_NEXT(a_fail_stops, m_tvalid && m_tready && m_tuser == K_STATUS && m_tdata[49:48] == STAT_FAIL, !m_tvalid)
endmodule
